### rtl/lifting_wavelet_forward_1d_defines.svh
`ifndef LIFTING_WAVELET_FORWARD_1D_DEFINES_SVH
`define LIFTING_WAVELET_FORWARD_1D_DEFINES_SVH

// same-cycle implication
`define LWF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LWF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lwf1d_pkg.sv
package lwf1d_pkg;

  localparam int PixelW  = 8;
  localparam int CoeffW  = 12;
  localparam int WorkW   = 14;
  localparam int EvenTaps = 4;
  localparam int OddTaps  = 3;

  localparam logic [WorkW-1:0] DetailOffset = WorkW'(128);
  localparam logic signed [WorkW-1:0] CoeffMax = WorkW'(2047);
  localparam logic signed [WorkW-1:0] CoeffMin = -WorkW'(2048);

  typedef logic [PixelW-1:0]        pixel_t;
  typedef logic signed [CoeffW-1:0] coeff_t;
  typedef logic signed [WorkW-1:0]  work_t;

  function automatic coeff_t sat12(input work_t v);
    coeff_t r;
    if (v > CoeffMax) begin
      r = CoeffMax[CoeffW-1:0];
    end else if (v < CoeffMin) begin
      r = CoeffMin[CoeffW-1:0];
    end else begin
      r = v[CoeffW-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/lifting_wavelet_forward_1d.sv
// Path: an item is captured in the input register, and its result is loaded into
// the result register, from which it can be taken.
// Throughput: one item per cycle; the input register and the result register
// each advance whenever the stage after them is empty or draining.
// Reset (rst, synchronous, active high) empties both stages and clears the
// even and odd lines, the saved detail and the saved approximation to zero.
`include "lifting_wavelet_forward_1d_defines.svh"

module lifting_wavelet_forward_1d
  import lwf1d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  logic [1:0]  s_axis_tuser,   // [0] is_even, [1] row_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [11:0] coeff, [15:12] zero
  output logic [0:0]  m_axis_tuser    // [0] is_detail
);

  // input register
  logic   in_valid;
  pixel_t in_pixel;
  logic   in_even;
  logic   in_first;

  // line state
  logic [EvenTaps-1:0][PixelW-1:0] even_line;
  logic [OddTaps-1:0][PixelW-1:0]  odd_line;
  coeff_t previous_detail;
  coeff_t saved_approx;

  // result register
  logic   out_valid;
  coeff_t out_coeff;
  logic   out_detail;

  logic   adv;
  pixel_t o0;
  logic [PixelW:0]   sum_near;
  logic [PixelW:0]   sum_far;
  logic [PixelW+4:0] near9;
  work_t  pdiff;
  work_t  pred;
  work_t  d_raw;
  coeff_t d;
  work_t  d_wide;
  work_t  dd_sum;
  work_t  c_div;
  work_t  c_raw;
  coeff_t c;

  assign adv           = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || adv;

  always_comb begin
    // even item uses the odd line as it stands; odd item sees it shifted
    o0       = in_even ? odd_line[0] : odd_line[1];
    sum_near = {1'b0, even_line[1]} + {1'b0, even_line[2]};
    sum_far  = {1'b0, even_line[0]} + {1'b0, even_line[3]};
    near9    = {1'b0, sum_near, 3'b000} + {4'b0000, sum_near};
    pdiff    = $signed({1'b0, near9}) - $signed({5'b00000, sum_far});
    // truncate toward zero
    pred     = $signed(pdiff + {{(WorkW-4){1'b0}}, {4{pdiff[WorkW-1]}}}) >>> 4;
    d_raw    = $signed({{(WorkW-PixelW){1'b0}}, o0}) - pred - $signed(DetailOffset);
    d        = sat12(d_raw);
    d_wide   = {{(WorkW-CoeffW){d[CoeffW-1]}}, d};
    dd_sum   = d_wide + {{(WorkW-CoeffW){previous_detail[CoeffW-1]}}, previous_detail};
    if (in_first) begin
      c_div = $signed(d_wide + {{(WorkW-1){1'b0}}, d_wide[WorkW-1]}) >>> 1;
    end else begin
      c_div = $signed(dd_sum + {{(WorkW-2){1'b0}}, {2{dd_sum[WorkW-1]}}}) >>> 2;
    end
    c_raw    = $signed({{(WorkW-PixelW){1'b0}}, even_line[1]}) + c_div;
    c        = sat12(c_raw);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_pixel <= s_axis_tdata;
      in_even  <= s_axis_tuser[0];
      in_first <= s_axis_tuser[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      even_line       <= '0;
      odd_line        <= '0;
      previous_detail <= '0;
      saved_approx    <= '0;
    end else if (adv) begin
      if (in_even) begin
        previous_detail <= d;
        saved_approx    <= c;
        even_line       <= {in_pixel, even_line[EvenTaps-1:1]};
      end else begin
        odd_line        <= {in_pixel, odd_line[OddTaps-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      out_coeff  <= in_even ? c : d;
      out_detail <= !in_even;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = {4'b0000, out_coeff};
  assign m_axis_tuser[0] = out_detail;

  `LWF_ASSERT_NEXT(a_odd_is_detail, adv && !in_even, m_axis_tuser[0], "odd item must give a detail")
  `LWF_ASSERT_NEXT(a_even_emits_saved, adv && in_even, $signed(m_axis_tdata[11:0]) == saved_approx, "even item must emit the saved approximation")
  `LWF_ASSERT_NEXT(a_odd_keeps_even, adv && !in_even, $stable(even_line) && $stable(saved_approx), "odd item disturbed even state")
  `LWF_ASSERT_NEXT(a_stall_holds_input, in_valid && !adv, in_valid && $stable(in_pixel), "stalled input stage lost its item")
  `LWF_ASSERT_NOW(a_out_rise_from_stage, $rose(m_axis_tvalid), $past(adv), "result appeared without a stage advance")

endmodule
